### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page table engine.
// Each macro expands to one labelled concurrent assertion that is switched
// off while the synchronous reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold at the edge where ante holds.
`define TLPT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold at the edge after the one where ante holds.
`define TLPT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// tlpt_pkg
// Beat types, command and status codes, and the control interface shared by
// the page table engine's controller and datapath.
// ----------------------------------------------------------------------------
package tlpt_pkg;

  localparam int DIR_ENTRIES = 1024;
  localparam int DIR_AW      = 10;
  localparam int TBL_ENTRIES = 1024;
  localparam int TBL_AW      = 10;
  localparam int OFFSET_W    = 12;
  localparam int CNT_W       = 24;
  localparam int SCNT_W      = 5;

  localparam logic [CNT_W-1:0]  COUNT_MAX      = 24'hFFFFFF;
  localparam logic [SCNT_W-1:0] SLOT_LIMIT_RST = 5'd16;

  localparam int FLAG_PRESENT_BIT = 0;
  localparam int FLAG_USER_BIT    = 2;

  localparam logic [1:0] CMD_MAP     = 2'd0;
  localparam logic [1:0] CMD_UNMAP   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_SETUSER = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_DIR_ABSENT  = 2'd1;
  localparam logic [1:0] ST_PAGE_ABSENT = 2'd2;
  localparam logic [1:0] ST_NO_SLOT     = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] vaddr;
    logic [31:0] target_addr;
    logic [11:0] entry_flags;
  } tlpt_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [31:0]       phys_result;
    logic              is_mapped;
    logic              dir_user;
    logic [CNT_W-1:0]  mapped_count;
    logic [SCNT_W-1:0] slots_used;
  } tlpt_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic page_rd;
    logic commit;
  } tlpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
  } tlpt_stat_t;

endpackage

### rtl/tlpt_ctrl.sv
// ----------------------------------------------------------------------------
// tlpt_ctrl
// Sequencer for the page table engine: runs the clearing pass after reset,
// then steps each beat through the directory read, the page read and commit.
// ----------------------------------------------------------------------------
module tlpt_ctrl import tlpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  tlpt_stat_t stat,
  output tlpt_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_DIR,
    S_PAGE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    cmd.clr_step = (state_r == S_CLEAR);
    cmd.load     = accept;
    cmd.page_rd  = (state_r == S_DIR);
    cmd.commit   = (state_r == S_PAGE) && out_free;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_DIR;
      end
      S_DIR: begin
        state_nxt = S_PAGE;
      end
      S_PAGE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
    out_valid_nxt = cmd.commit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### rtl/tlpt_dp.sv
// ----------------------------------------------------------------------------
// tlpt_dp
// Datapath of the page table engine: directory and page memories, the slot
// and mapping counters, the slot limit register and the result register.
// ----------------------------------------------------------------------------
module tlpt_dp import tlpt_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SCNT_W-1:0] cfg_wdata,
  input  tlpt_in_t          in_data,
  input  tlpt_cmd_t         cmd,
  output tlpt_stat_t        stat,
  output tlpt_out_t         out_data
);

  localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int PAGE_DEPTH = TABLE_SLOTS * TBL_ENTRIES;
  localparam int PAGE_AW    = $clog2(PAGE_DEPTH);
  localparam int DIR_W      = SLOT_W + 2;

  localparam logic [PAGE_AW-1:0] CLR_LAST = PAGE_AW'(PAGE_DEPTH - 1);

  logic [DIR_W-1:0] dir_mem  [0:DIR_ENTRIES-1];
  logic [31:0]      page_mem [0:PAGE_DEPTH-1];

  tlpt_in_t          item_r;
  logic [DIR_W-1:0]  dir_q_r;
  logic [31:0]       page_q_r;
  logic [PAGE_AW-1:0] page_addr_r;
  logic [PAGE_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [SCNT_W-1:0] slot_cnt_r, slot_cnt_nxt;
  logic [CNT_W-1:0]  map_cnt_r, map_cnt_nxt;
  logic [SCNT_W-1:0] slot_limit_r, slot_limit_nxt;
  tlpt_out_t         out_r;

  logic                     dir_present;
  logic                     dir_user;
  logic [SLOT_W-1:0]        dir_slot;
  logic [SCNT_W+SLOT_W-1:0] slot_ext;
  logic [SLOT_W-1:0]        alloc_slot;
  logic [SLOT_W-1:0]        slot_sel;
  logic [SLOT_W+TBL_AW-1:0] page_full_addr;
  logic [PAGE_AW-1:0]       page_rd_addr;
  logic                     slots_full;
  logic                     page_present;

  logic             dir_wr;
  logic [DIR_W-1:0] dir_wdata;
  logic             page_wr;
  logic [31:0]      page_wdata;
  tlpt_out_t        result;

  assign dir_present = dir_q_r[DIR_W-1];
  assign dir_user    = dir_q_r[DIR_W-2];
  assign dir_slot    = dir_q_r[SLOT_W-1:0];

  assign slot_ext   = {{SLOT_W{1'b0}}, slot_cnt_r};
  assign alloc_slot = slot_ext[SLOT_W-1:0];

  // An absent directory entry will receive the next free slot, which is
  // still all zero, so that address is read instead.
  assign slot_sel       = dir_present ? dir_slot : alloc_slot;
  assign page_full_addr = {slot_sel, item_r.vaddr[21:12]};
  assign page_rd_addr   = page_full_addr[PAGE_AW-1:0];

  assign slots_full   = (slot_cnt_r >= slot_limit_r) ||
                        (32'(slot_cnt_r) >= 32'(TABLE_SLOTS));
  assign page_present = page_q_r[FLAG_PRESENT_BIT];

  assign stat.clr_last = (clr_addr_r == CLR_LAST);
  assign out_data      = out_r;

  always_comb begin
    logic nd_user;
    dir_wr       = 1'b0;
    dir_wdata    = dir_q_r;
    page_wr      = 1'b0;
    page_wdata   = page_q_r;
    slot_cnt_nxt = slot_cnt_r;
    map_cnt_nxt  = map_cnt_r;
    nd_user      = dir_user;
    result              = '0;
    result.status       = ST_OK;
    result.dir_user     = dir_user;
    unique case (item_r.command)
      CMD_MAP: begin
        if (!dir_present && slots_full) begin
          result.status = ST_NO_SLOT;
        end else begin
          nd_user = (dir_present && dir_user) || item_r.entry_flags[FLAG_USER_BIT];
          dir_wr  = 1'b1;
          if (dir_present) begin
            dir_wdata = {1'b1, nd_user, dir_slot};
          end else begin
            dir_wdata    = {1'b1, nd_user, alloc_slot};
            slot_cnt_nxt = slot_cnt_r + 1'b1;
          end
          page_wr    = 1'b1;
          page_wdata = {item_r.target_addr[31:OFFSET_W], item_r.entry_flags};
          if (map_cnt_r != COUNT_MAX) map_cnt_nxt = map_cnt_r + 1'b1;
          result.is_mapped = item_r.entry_flags[FLAG_PRESENT_BIT];
          result.dir_user  = nd_user;
        end
      end
      CMD_UNMAP: begin
        if (!dir_present) begin
          result.status = ST_DIR_ABSENT;
        end else if (!page_present) begin
          result.status = ST_PAGE_ABSENT;
        end else begin
          page_wr    = 1'b1;
          page_wdata = '0;
          if (map_cnt_r != '0) map_cnt_nxt = map_cnt_r - 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (!dir_present) begin
          result.status = ST_DIR_ABSENT;
        end else if (!page_present) begin
          result.status = ST_PAGE_ABSENT;
        end else begin
          result.phys_result = {page_q_r[31:OFFSET_W],
                                item_r.vaddr[OFFSET_W-1:0]};
          result.is_mapped   = 1'b1;
        end
      end
      CMD_SETUSER: begin
        if (!dir_present) begin
          result.status = ST_DIR_ABSENT;
        end else begin
          dir_wr          = 1'b1;
          dir_wdata       = {1'b1, 1'b1, dir_slot};
          result.dir_user = 1'b1;
          if (!page_present) begin
            result.status = ST_PAGE_ABSENT;
          end else begin
            page_wr    = 1'b1;
            page_wdata = page_q_r;
            page_wdata[FLAG_USER_BIT] = 1'b1;
            result.is_mapped = 1'b1;
          end
        end
      end
    endcase
    result.mapped_count = map_cnt_nxt;
    result.slots_used   = slot_cnt_nxt;
  end

  always_comb begin
    clr_addr_nxt   = cmd.clr_step ? clr_addr_r + 1'b1 : clr_addr_r;
    slot_limit_nxt = cfg_we ? cfg_wdata : slot_limit_r;
  end

  // Directory memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      dir_mem[clr_addr_r[DIR_AW-1:0]] <= '0;
    end else if (cmd.commit && dir_wr) begin
      dir_mem[item_r.vaddr[31:22]] <= dir_wdata;
    end
    if (cmd.load) begin
      dir_q_r <= dir_mem[in_data.vaddr[31:22]];
    end
  end

  // Page entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      page_mem[clr_addr_r] <= '0;
    end else if (cmd.commit && page_wr) begin
      page_mem[page_addr_r] <= page_wdata;
    end
    if (cmd.page_rd) begin
      page_q_r <= page_mem[page_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.page_rd) page_addr_r <= page_rd_addr;
    if (cmd.commit) out_r <= result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      slot_cnt_r   <= '0;
      map_cnt_r    <= '0;
      slot_limit_r <= SLOT_LIMIT_RST;
    end else begin
      clr_addr_r   <= clr_addr_nxt;
      slot_limit_r <= slot_limit_nxt;
      if (cmd.commit) begin
        slot_cnt_r <= slot_cnt_nxt;
        map_cnt_r  <= map_cnt_nxt;
      end
    end
  end

endmodule

### rtl/two_level_page_table_engine.sv
// ----------------------------------------------------------------------------
// two_level_page_table_engine: 32-bit two-level page table with 4 KB pages.
// Each beat passes through the dependent directory read and then the page entry
// read, each registered; a new beat is accepted only once the last one commits.
// After reset a clearing pass over every page entry holds in_ready low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_level_page_table_engine import tlpt_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: slot limit, written whenever cfg_we is high.
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  // Command channel.
  input  logic        in_valid,
  output logic        in_ready,
  input  tlpt_in_t    in_data,
  // Result channel.
  output logic        out_valid,
  input  logic        out_ready,
  output tlpt_out_t   out_data
);

  // The controller and datapath talk only through these two structures.
  // The controller owns sequencing and the result valid flag; the datapath
  // owns both memories, the counters and the result register itself.
  tlpt_cmd_t  cmd;
  tlpt_stat_t stat;

  // Sequence of one beat: at the accepting edge the directory entry for
  // address bits 31..22 is read. In the next cycle the entry decides which
  // slot to use (its own, or the next free one for a map that allocates)
  // and the page entry is read. Then the result is computed,
  // the memories and counters are updated and the result register loaded.
  // If an earlier result is still waiting there, the commit is held back
  // until it is taken, so a new beat can be accepted while a result waits.
  tlpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Slots are handed out in order and never freed, so after the clearing
  // pass a newly allocated slot always reads as zero.
  tlpt_dp #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // Only one beat is in flight: acceptance closes the input until commit.
  `TLPT_ASSERT_NXT(a_single_beat, clk, rst_n, in_valid && in_ready, !in_ready, "beat accepted while another is in flight")

  // With the result register empty when a beat is accepted, its result appears without a stall.
  `TLPT_ASSERT_IMP(a_result_latency, clk, rst_n, $past(in_valid && in_ready, 3) && !$past(out_valid, 3), out_valid, "result not delivered after three cycles")

  // A failed command never carries a translated address.
  `TLPT_ASSERT_IMP(a_phys_on_error, clk, rst_n, out_valid && (out_data.status != ST_OK), out_data.phys_result == 32'd0, "non-zero address with error status")

  // Allocation can never go beyond the slot pool.
  `TLPT_ASSERT_IMP(a_slot_bound, clk, rst_n, out_valid, 32'(out_data.slots_used) <= 32'(TABLE_SLOTS), "slots used exceeds pool size")

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for two_level_page_table_engine
// Drives map, unmap, lookup and set-user beats through the valid/ready
// command channel. A mirror of the directory, the slot pool and the page
// entries predicts every result beat, which is then compared field by field.
// The slot limit is stepped through several values, the extremes among them.
// ----------------------------------------------------------------------------
module tb;
  import tlpt_pkg::*;

  localparam int POOL_SLOTS = 16;
  // The slowest correct run is the clearing pass plus every beat with its longest
  // random gaps and stalls; this limit leaves a wide margin above that.
  localparam int CYCLE_LIMIT = 600000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  tlpt_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  tlpt_out_t out_data;

  int unsigned cycles = 0;

  // Address pools: most beats land on a few directory and page indexes so that
  // maps, remaps, unmaps and lookups meet the same entries again and again.
  logic [9:0] dir_pool [20];
  logic [9:0] page_pool [8];
  // Calm stretches: while set, that side does not idle at all.
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  always #5 clk = ~clk;

  two_level_page_table_engine #(.TABLE_SLOTS(POOL_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Mirror of the page tables. Each accepted command beat is walked through the
  // mirror at once, and the resulting beat is queued until the block delivers it.
  class page_table_mirror;
    bit          dir_present [DIR_ENTRIES];
    bit          dir_user    [DIR_ENTRIES];
    int          dir_slot    [DIR_ENTRIES];
    bit [31:0]   page_entry  [POOL_SLOTS*TBL_ENTRIES];
    int          slots_taken = 0;
    bit [CNT_W-1:0] map_count = '0;
    bit [4:0]    slot_limit = SLOT_LIMIT_RST;
    tlpt_out_t   owed_results [$];
    int unsigned faults = 0;

    function int entry_at(int pd, logic [31:0] va);
      return (dir_slot[pd] % POOL_SLOTS) * TBL_ENTRIES + int'(va[21:12]);
    endfunction

    function tlpt_out_t walk_tables(tlpt_in_t c);
      int        pd;
      int        bound;
      logic [1:0] st;
      logic [31:0] phys;
      tlpt_out_t r;
      pd = int'(c.vaddr[31:22]);
      bound = (slot_limit < POOL_SLOTS) ? int'(slot_limit) : POOL_SLOTS;
      st = ST_OK;
      phys = '0;
      case (c.command)
        CMD_MAP: begin
          // A fresh directory entry needs a slot; without one nothing changes.
          if (!dir_present[pd] && slots_taken >= bound) begin
            st = ST_NO_SLOT;
          end else begin
            if (!dir_present[pd]) begin
              dir_present[pd] = 1'b1;
              dir_user[pd] = 1'b0;
              dir_slot[pd] = slots_taken;
              slots_taken++;
            end
            if (c.entry_flags[FLAG_USER_BIT]) dir_user[pd] = 1'b1;
            page_entry[entry_at(pd, c.vaddr)] = {c.target_addr[31:12], c.entry_flags};
            if (map_count != COUNT_MAX) map_count++;
          end
        end
        CMD_UNMAP: begin
          if (!dir_present[pd]) begin
            st = ST_DIR_ABSENT;
          end else if (!page_entry[entry_at(pd, c.vaddr)][FLAG_PRESENT_BIT]) begin
            st = ST_PAGE_ABSENT;
          end else begin
            page_entry[entry_at(pd, c.vaddr)] = '0;
            if (map_count != '0) map_count--;
          end
        end
        CMD_LOOKUP: begin
          if (!dir_present[pd]) begin
            st = ST_DIR_ABSENT;
          end else if (!page_entry[entry_at(pd, c.vaddr)][FLAG_PRESENT_BIT]) begin
            st = ST_PAGE_ABSENT;
          end else begin
            phys = {page_entry[entry_at(pd, c.vaddr)][31:12], c.vaddr[11:0]};
          end
        end
        default: begin
          // Set-user marks the directory entry even when the page is absent.
          if (!dir_present[pd]) begin
            st = ST_DIR_ABSENT;
          end else begin
            dir_user[pd] = 1'b1;
            if (!page_entry[entry_at(pd, c.vaddr)][FLAG_PRESENT_BIT])
              st = ST_PAGE_ABSENT;
            else
              page_entry[entry_at(pd, c.vaddr)][FLAG_USER_BIT] = 1'b1;
          end
        end
      endcase
      r.status       = st;
      r.phys_result  = phys;
      r.is_mapped    = dir_present[pd] &&
                       page_entry[entry_at(pd, c.vaddr)][FLAG_PRESENT_BIT];
      r.dir_user     = dir_user[pd];
      r.mapped_count = map_count;
      r.slots_used   = 5'(slots_taken);
      return r;
    endfunction

    function void accept_command(tlpt_in_t c);
      owed_results.push_back(walk_tables(c));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        faults++;
      end
    endfunction

    function void check_result(tlpt_out_t got);
      tlpt_out_t want;
      if (owed_results.size() == 0) begin
        $error("result beat with nothing outstanding: %0h", got);
        faults++;
        return;
      end
      want = owed_results.pop_front();
      check_field("status",       32'(want.status),       32'(got.status));
      check_field("phys_result",  want.phys_result,       got.phys_result);
      check_field("is_mapped",    32'(want.is_mapped),    32'(got.is_mapped));
      check_field("dir_user",     32'(want.dir_user),     32'(got.dir_user));
      check_field("mapped_count", 32'(want.mapped_count), 32'(got.mapped_count));
      check_field("slots_used",   32'(want.slots_used),   32'(got.slots_used));
    endfunction
  endclass

  page_table_mirror mirror;

  // The run is bounded by a cycle count; running past it means something hung.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function tlpt_in_t command_beat(logic [1:0] cmd, logic [31:0] va, logic [31:0] pa,
                                  logic [11:0] fl);
    tlpt_in_t c;
    c.command      = cmd;
    c.vaddr        = va;
    c.target_addr  = pa;
    c.entry_flags  = fl;
    return c;
  endfunction

  // Random beat. Mostly pooled addresses with a present flag; the remainder is
  // scattered addresses and not-present maps, which also exhausts the slot pool.
  function tlpt_in_t random_command();
    int         pick;
    logic [9:0] pd;
    logic [9:0] pt;
    logic [11:0] fl;
    logic [1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 35)      cmd = CMD_MAP;
    else if (pick < 55) cmd = CMD_UNMAP;
    else if (pick < 85) cmd = CMD_LOOKUP;
    else                cmd = CMD_SETUSER;
    pd = ($urandom_range(0, 9) != 0) ? dir_pool[$urandom_range(0, 19)]
                                     : 10'($urandom_range(0, 1023));
    pt = ($urandom_range(0, 9) != 0) ? page_pool[$urandom_range(0, 7)]
                                     : 10'($urandom_range(0, 1023));
    fl = 12'($urandom);
    if ($urandom_range(0, 99) < 85) fl[FLAG_PRESENT_BIT] = 1'b1;
    return command_beat(cmd, {pd, pt, 12'($urandom)}, $urandom, fl);
  endfunction

  // Presents one command beat after a random gap and returns at the edge where
  // it is taken. Valid stays high into the next beat when there is no gap.
  task automatic send_command(tlpt_in_t c);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    do @(posedge clk); while (!in_ready);
    mirror.accept_command(c);
  endtask

  task automatic send_random(int count);
    repeat (count) send_command(random_command());
  endtask

  // Result side: stalls for a random number of cycles before each beat, then
  // holds ready until a result arrives and checks it.
  task automatic receive_results();
    int stall;
    forever begin
      if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
      stall = recv_calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      mirror.check_result(out_data);
    end
  endtask

  // The slot limit is only changed once every owed result has come back and
  // the pipeline has had time to drain.
  task automatic set_slot_limit(logic [4:0] value);
    in_valid <= 1'b0;
    while (mirror.owed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mirror.slot_limit = value;
  endtask

  initial begin
    mirror = new();
    // Pools include the lowest and highest index so every address bit toggles.
    dir_pool[0] = '0;
    dir_pool[1] = '1;
    for (int i = 2; i < 20; i++) dir_pool[i] = 10'($urandom_range(0, 1023));
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < 8; i++) page_pool[i] = 10'($urandom_range(0, 1023));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    fork
      receive_results();
    join_none

    // A limit of zero: no map can obtain a slot, and every other command finds
    // the directory entry absent.
    set_slot_limit(5'd0);
    send_command(command_beat(CMD_MAP,     32'h0000_0000, 32'hFFFF_F000, 12'h001));
    send_command(command_beat(CMD_UNMAP,   32'h0000_0000, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_LOOKUP,  32'hFFFF_FFFF, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_SETUSER, 32'h1234_5678, 32'h0000_0000, 12'h000));

    // A single slot: the first map takes it and a map into another directory
    // entry then runs out.
    set_slot_limit(5'd1);
    send_command(command_beat(CMD_MAP,     32'h0000_0ABC, 32'hFFFF_FFFF, 12'h007));
    send_command(command_beat(CMD_LOOKUP,  32'h0000_0ABC, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_MAP,     32'hFFFF_F000, 32'h1111_1000, 12'h001));
    // Not-present map: written and counted, but it does not translate.
    send_command(command_beat(CMD_MAP,     32'h003F_F123, 32'h0000_0000, 12'hFF8));
    send_command(command_beat(CMD_LOOKUP,  32'h003F_F000, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_UNMAP,   32'h003F_F000, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_SETUSER, 32'h003F_F000, 32'h0000_0000, 12'h000));
    // Remap of a present entry counts as a fresh mapping.
    send_command(command_beat(CMD_MAP,     32'h0000_0FFF, 32'h1234_5000, 12'h001));
    send_command(command_beat(CMD_SETUSER, 32'h0000_0000, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_LOOKUP,  32'h0000_0FFF, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_UNMAP,   32'h0000_0000, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_LOOKUP,  32'h0000_0000, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_MAP,     32'h003F_F000, 32'hABCD_E000, 12'hFFF));

    // A few more slots, then the top directory entry and random traffic.
    set_slot_limit(5'd4);
    send_command(command_beat(CMD_MAP,     32'hFFFF_FFFF, 32'hFFFF_F000, 12'h003));
    send_command(command_beat(CMD_LOOKUP,  32'hFFFF_FFFF, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_SETUSER, 32'hFFC0_0000, 32'h0000_0000, 12'h000));
    send_command(command_beat(CMD_UNMAP,   32'hFFFF_F000, 32'h0000_0000, 12'h000));
    send_random(220);

    // A limit above the pool is bounded by the pool size.
    set_slot_limit(5'd31);
    send_random(300);
    set_slot_limit(5'd16);
    send_random(300);
    set_slot_limit(5'd2);
    send_random(260);

    in_valid <= 1'b0;
    while (mirror.owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mirror.faults == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/tlpt_pkg.sv
rtl/tlpt_ctrl.sv
rtl/tlpt_dp.sv
rtl/two_level_page_table_engine.sv
tb/sv/tb.sv
